FILE: hdl/nci_pkg.sv
// Package for the nearest palette color search: candidate type, tree sizes
// and the constant palette ROM. No dependencies.
package nci_pkg;

  // One palette color, 9 bits per component (two reds reach 256).
  typedef struct packed {
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
  } rgb_t;

  // Squared distance of one entry and its zero-based position.
  typedef struct packed {
    logic [17:0] sq_dist;
    logic [7:0]  idx;
  } cand_t;

  localparam int ROM_SIZE = 255;
  localparam int LEAVES   = 256;
  localparam int LEVELS   = 8;

  // Larger than any real distance (3 * 256 * 256), so padding never wins.
  localparam logic [17:0] DIST_MAX = 18'h3FFFF;

  localparam rgb_t PAL_ROM [0:ROM_SIZE-1] = '{
    '{255,0,0},'{255,255,0},'{0,255,0},'{0,255,255},'{0,0,255},
    '{255,0,255},'{255,255,255},'{255,255,255},'{255,255,255},'{255,9,0},
    '{255,128,128},'{166,0,0},'{166,83,83},'{128,0,0},'{128,64,64},
    '{77,0,0},'{77,38,38},'{38,0,0},'{38,19,19},'{255,64,0},
    '{255,160,128},'{166,42,0},'{166,104,83},'{128,32,0},'{128,80,64},
    '{77,19,0},'{77,48,38},'{38,10,0},'{38,24,19},'{256,128,0},
    '{256,192,0},'{166,83,0},'{166,125,83},'{128,64,0},'{128,96,64},
    '{77,38,0},'{77,58,38},'{38,19,0},'{38,29,19},'{255,192,0},
    '{255,224,128},'{166,125,0},'{166,146,83},'{128,96,0},'{128,112,64},
    '{77,58,0},'{77,67,38},'{38,29,0},'{38,34,19},'{255,255,0},
    '{255,255,128},'{166,166,0},'{166,166,83},'{128,128,0},'{128,128,64},
    '{77,77,0},'{77,77,38},'{38,38,0},'{38,38,19},'{192,255,0},
    '{224,255,128},'{125,166,0},'{146,166,83},'{96,128,0},'{112,128,64},
    '{58,77,0},'{67,77,38},'{29,38,0},'{34,38,19},'{128,255,0},
    '{192,255,128},'{83,166,0},'{125,166,83},'{64,128,0},'{96,128,64},
    '{38,77,0},'{58,77,38},'{19,38,0},'{29,38,19},'{64,255,0},
    '{160,255,128},'{42,160,0},'{104,160,80},'{32,128,0},'{80,128,64},
    '{19,77,0},'{48,77,38},'{10,38,0},'{24,38,19},'{0,255,0},
    '{128,255,128},'{0,166,0},'{83,166,83},'{0,128,0},'{64,128,64},
    '{0,77,0},'{38,77,38},'{0,38,0},'{19,38,19},'{0,255,64},
    '{128,255,160},'{0,166,42},'{83,166,118},'{0,128,32},'{64,128,80},
    '{0,77,19},'{38,77,48},'{0,38,10},'{19,38,24},'{0,255,128},
    '{128,255,192},'{0,166,83},'{83,166,125},'{0,128,64},'{64,128,96},
    '{0,77,38},'{38,77,58},'{0,38,19},'{19,38,29},'{0,255,192},
    '{128,255,224},'{0,166,125},'{83,166,146},'{0,128,96},'{64,128,112},
    '{0,77,58},'{38,77,67},'{0,38,29},'{19,38,34},'{0,255,255},
    '{128,255,255},'{0,166,166},'{83,166,166},'{0,128,128},'{64,128,128},
    '{0,77,77},'{38,77,77},'{0,38,38},'{19,38,38},'{0,192,255},
    '{128,224,255},'{0,125,166},'{83,146,166},'{0,96,128},'{64,112,128},
    '{0,58,77},'{38,67,77},'{0,29,38},'{19,34,38},'{0,128,255},
    '{128,192,255},'{0,83,166},'{83,125,166},'{0,64,128},'{64,96,128},
    '{0,38,77},'{38,58,77},'{0,19,38},'{19,29,38},'{0,64,255},
    '{128,160,255},'{0,42,166},'{83,104,166},'{0,32,128},'{64,80,128},
    '{0,19,77},'{38,48,77},'{0,10,38},'{19,24,38},'{0,0,255},
    '{128,128,255},'{0,0,166},'{83,83,166},'{0,0,128},'{64,64,128},
    '{0,0,77},'{38,38,77},'{0,0,38},'{19,19,38},'{64,0,255},
    '{160,128,255},'{42,0,166},'{104,83,166},'{32,0,128},'{80,64,128},
    '{19,0,77},'{48,38,77},'{10,0,38},'{24,19,38},'{128,0,255},
    '{192,128,255},'{83,0,166},'{125,83,166},'{64,0,128},'{96,64,128},
    '{38,0,77},'{58,38,77},'{19,0,38},'{29,19,38},'{192,0,255},
    '{224,128,255},'{125,0,166},'{146,83,166},'{96,0,128},'{112,64,128},
    '{58,0,77},'{67,38,77},'{29,0,38},'{34,19,38},'{255,0,255},
    '{255,128,255},'{166,0,166},'{166,83,166},'{128,0,128},'{128,64,128},
    '{77,0,77},'{77,38,77},'{38,0,38},'{38,19,38},'{255,0,192},
    '{255,128,224},'{166,0,125},'{166,83,146},'{128,0,96},'{128,64,112},
    '{77,0,58},'{77,38,67},'{38,0,29},'{38,19,34},'{255,0,128},
    '{255,128,192},'{166,0,83},'{166,83,125},'{128,0,64},'{128,64,96},
    '{77,0,38},'{77,38,58},'{38,0,19},'{38,19,29},'{255,0,64},
    '{255,128,160},'{166,0,42},'{166,83,104},'{128,0,32},'{128,64,80},
    '{77,0,19},'{77,38,48},'{38,0,10},'{38,19,24},'{84,84,84},
    '{119,119,119},'{153,153,153},'{187,187,187},'{222,222,222},'{255,255,255}
  };

endpackage

FILE: hdl/nci_tree.sv
// Registered minimum tree over all palette candidates, one level per stage.
// Depends on nci_pkg for cand_t, LEAVES and LEVELS.
module nci_tree import nci_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  leaf_valid,
  input  cand_t leaves [LEAVES],
  output logic  best_valid,
  output cand_t best
);

  logic [LEVELS-1:0] vld;

  // Each node keeps the smaller distance; on a tie the left (lower) one wins.
  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    cand_t node [LEAVES >> (l + 1)];
    for (genvar n = 0; n < (LEAVES >> (l + 1)); n++) begin : g_node
      if (l == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (leaves[2*n+1].sq_dist < leaves[2*n].sq_dist) begin
            node[n] <= leaves[2*n+1];
          end else begin
            node[n] <= leaves[2*n];
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (g_lvl[l-1].node[2*n+1].sq_dist < g_lvl[l-1].node[2*n].sq_dist) begin
            node[n] <= g_lvl[l-1].node[2*n+1];
          end else begin
            node[n] <= g_lvl[l-1].node[2*n];
          end
        end
      end
    end
  end

  // Valid bits follow the beat down the tree.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LEVELS-2:0], leaf_valid};
    end
  end

  assign best_valid = vld[LEVELS-1];
  assign best       = g_lvl[LEVELS-1].node[0];

endmodule

FILE: hdl/nearest_palette_color_index_top.sv
// Top level of the nearest palette color search: distance stages and the
// minimum tree. Depends on nci_pkg and nci_tree.
//
// Usage: drive red, green and blue and pulse start. A beat is taken at every
// rising edge with start high; busy is always low, so a new pixel may enter
// every cycle and the sustained rate is one pixel per clock.
// The answer appears on color_index with done high for exactly one cycle,
// after passing the registered stages: one stage of absolute differences,
// one of squares, one of sums, and eight levels of the minimum tree over
// 256 leaves (the palette padded with unreachable distances).
// color_index is the one-based palette position of the nearest color by
// squared distance, the lowest position on ties.
// Results are not held: the receiver must take each one in its done cycle,
// there is no stall path. Synchronous reset clears only the valid bits; beats
// in flight at reset are dropped. There is no configuration and no state
// between pixels.
module nearest_palette_color_index_top import nci_pkg::*; #(
  parameter int PALETTE_ENTRIES = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       done,
  output logic [7:0] color_index
);

  localparam int N = (PALETTE_ENTRIES < 1) ? 1 :
                     ((PALETTE_ENTRIES > ROM_SIZE) ? ROM_SIZE : PALETTE_ENTRIES);

  logic        v1, v2, v3;
  logic [8:0]  dr [N];
  logic [8:0]  dg [N];
  logic [8:0]  db [N];
  logic [16:0] sr [N];
  logic [16:0] sg [N];
  logic [16:0] sb [N];
  cand_t       leaf_reg [N];
  cand_t       leaves [LEAVES];
  logic        best_valid;
  cand_t       best;

  assign busy = 1'b0;

  // Valid bits of the three distance stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_ent
    // Absolute component differences against this entry.
    always_ff @(posedge clk) begin
      dr[i] <= ({1'b0, red} >= PAL_ROM[i].r) ? ({1'b0, red} - PAL_ROM[i].r)
                                             : (PAL_ROM[i].r - {1'b0, red});
      dg[i] <= ({1'b0, green} >= PAL_ROM[i].g) ? ({1'b0, green} - PAL_ROM[i].g)
                                               : (PAL_ROM[i].g - {1'b0, green});
      db[i] <= ({1'b0, blue} >= PAL_ROM[i].b) ? ({1'b0, blue} - PAL_ROM[i].b)
                                              : (PAL_ROM[i].b - {1'b0, blue});
    end

    // Squares of the differences; 256 squared still fits 17 bits.
    always_ff @(posedge clk) begin
      sr[i] <= 17'({8'd0, dr[i]} * {8'd0, dr[i]});
      sg[i] <= 17'({8'd0, dg[i]} * {8'd0, dg[i]});
      sb[i] <= 17'({8'd0, db[i]} * {8'd0, db[i]});
    end

    // Sum into the leaf register of the tree.
    always_ff @(posedge clk) begin
      leaf_reg[i].sq_dist <= {1'b0, sr[i]} + {1'b0, sg[i]} + {1'b0, sb[i]};
      leaf_reg[i].idx     <= 8'(i);
    end

    assign leaves[i] = leaf_reg[i];
  end

  // Leaves past the palette never win.
  for (genvar i = N; i < LEAVES; i++) begin : g_pad
    assign leaves[i] = '{sq_dist: DIST_MAX, idx: '0};
  end

  nci_tree u_tree (
    .clk        (clk),
    .rst        (rst),
    .leaf_valid (v3),
    .leaves     (leaves),
    .best_valid (best_valid),
    .best       (best)
  );

  assign done        = best_valid;
  assign color_index = best.idx + 8'd1;

  // Every result traces back to a pixel taken a fixed latency earlier.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(start, 11))
    else $error("result without a pixel 11 cycles before");

  // The answer is a real palette position.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (color_index != 8'd0) && (color_index <= 8'(N)))
    else $error("color index out of palette range");

  // A pixel taken leads to a result after the pipeline latency.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##11 (done || $past(rst, 1) || $past(rst, 2) ||
                             $past(rst, 3) || $past(rst, 4) || $past(rst, 5) ||
                             $past(rst, 6) || $past(rst, 7) || $past(rst, 8) ||
                             $past(rst, 9) || $past(rst, 10) || rst))
    else $error("pixel lost in the pipeline");

endmodule

FILE: sim/nearest_palette_color_index_top_tb.sv
// Testbench for the nearest palette color search: drives pixels, predicts the
// nearest palette index and checks every answer in order. Depends on nci_pkg.
module nearest_palette_color_index_top_tb;
  import nci_pkg::*;

  // Holds predicted palette indexes in beat order and compares answers.
  class palette_scoreboard;
    logic [7:0] pending_index[$];
    int mismatches;
    int checked;

    // Predict the nearest palette entry for one accepted pixel.
    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int best_pos;
      int best_dist;
      int d;
      int dr, dg, db;
      int entries;
      best_pos = 0;
      best_dist = 0;
      entries = 255;
      for (int i = 0; i < entries; i++) begin
        dr = int'(r) - int'(PAL_ROM[i].r);
        dg = int'(g) - int'(PAL_ROM[i].g);
        db = int'(b) - int'(PAL_ROM[i].b);
        d = dr * dr + dg * dg + db * db;
        if (i == 0 || d < best_dist) begin
          best_dist = d;
          best_pos = i;
        end
      end
      pending_index.push_back(8'(best_pos + 1));
    endfunction

    // Compare one answer with the oldest prediction.
    function void check_index(logic [7:0] got);
      logic [7:0] want;
      if (pending_index.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer color_index=%0d", got);
      end else begin
        want = pending_index.pop_front();
        checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("color_index mismatch: expected %0d actual %0d", want, got);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [7:0] red, green, blue;
  logic done;
  logic [7:0] color_index;
  int cycles = 0;
  palette_scoreboard sb;

  localparam int LATENCY = 11;
  localparam int CYCLE_LIMIT = 200000;

  nearest_palette_color_index_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red(red), .green(green), .blue(blue),
    .done(done), .color_index(color_index)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Cycle counter with the run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sample answers and accepted beats at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_index(color_index);
      if (start && !busy) sb.note_pixel(red, green, blue);
    end
  end

  // Send one pixel, after an optional random gap, and hold it until it is taken.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int n;
    int k;
    int e;
    bit gaps;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    red = 8'd0;
    green = 8'd0;
    blue = 8'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corners of the cube, the gray ramp, ties and the wide reds.
    send_pixel(8'd0, 8'd0, 8'd0, 0);
    send_pixel(8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd255, 8'd0, 8'd0, 0);
    send_pixel(8'd0, 8'd255, 8'd0, 0);
    send_pixel(8'd0, 8'd0, 8'd255, 0);
    send_pixel(8'd255, 8'd255, 8'd0, 0);
    send_pixel(8'd0, 8'd255, 8'd255, 0);
    send_pixel(8'd255, 8'd0, 8'd255, 0);
    send_pixel(8'd255, 8'd128, 8'd0, 0);
    send_pixel(8'd255, 8'd192, 8'd0, 0);
    send_pixel(8'd255, 8'd9, 8'd0, 0);
    send_pixel(8'd84, 8'd84, 8'd84, 0);
    send_pixel(8'd119, 8'd119, 8'd119, 0);
    send_pixel(8'd153, 8'd153, 8'd153, 0);
    send_pixel(8'd187, 8'd187, 8'd187, 0);
    send_pixel(8'd222, 8'd222, 8'd222, 0);
    send_pixel(8'd128, 8'd128, 8'd128, 0);
    send_pixel(8'd170, 8'd85, 8'd85, 1);
    send_pixel(8'd1, 8'd2, 8'd3, 1);
    send_pixel(8'd254, 8'd253, 8'd252, 0);
    send_pixel(8'd19, 8'd19, 8'd19, 0);

    // Random: half on or near palette colors, half anywhere in the cube.
    for (n = 0; n < 600; n++) begin
      gaps = ($urandom_range(0, 3) != 0) && ((n / 50) % 2 == 0);
      if ($urandom_range(0, 1)) begin
        e = $urandom_range(0, ROM_SIZE - 1);
        k = $urandom_range(0, 6);
        send_pixel(8'(PAL_ROM[e].r > 255 ? 255 : PAL_ROM[e].r + $urandom_range(0, k)),
                   8'(PAL_ROM[e].g + $urandom_range(0, k)),
                   8'(PAL_ROM[e].b + $urandom_range(0, k)), gaps);
      end else begin
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), gaps);
      end
    end
    start <= 1'b0;

    // Drain the pipeline.
    while (sb.pending_index.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: nearest_palette_color_index_top.f
hdl/nci_pkg.sv
hdl/nci_tree.sv
hdl/nearest_palette_color_index_top.sv
sim/nearest_palette_color_index_top_tb.sv
